// ----- design/hkts_pkg.sv -----
// ----------------------------------------------------------------------------
// hkts_pkg
// Shared types and constants for the histogram top-K select core.
// ----------------------------------------------------------------------------
package hkts_pkg;

  localparam int TOP_K_DEF   = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam int IDX_W       = 8;
  localparam int CNT_W       = 32;
  localparam int RANK_W      = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic MODE_LARGEST  = 1'b0;
  localparam logic MODE_SMALLEST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FIRST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LAST  = 2'd2;

  localparam logic [IDX_W-1:0] RANGE_LAST_RST = 8'hff;

  typedef struct packed {
    logic             select_mode;
    logic [IDX_W-1:0] range_first;
    logic [IDX_W-1:0] range_last;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    logic             elig;
    logic             last;
  } bin_req_t;

endpackage

// ----- design/hkts_front.sv -----
// ----------------------------------------------------------------------------
// hkts_front
// Input side: unpacks a bin request and tags it with its eligibility.
// ----------------------------------------------------------------------------
module hkts_front
  import hkts_pkg::*;
(
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tlast,
  input  cfg_t                  cfg,
  input  logic                  q_ready,
  output logic                  q_push,
  output bin_req_t              q_req
);

  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] cnt;
  logic             in_range;
  logic             cnt_ok;

  assign idx      = in_tdata[IDX_W-1:0];
  assign cnt      = in_tdata[IDX_W+CNT_W-1:IDX_W];
  assign in_range = (idx >= cfg.range_first) && (idx <= cfg.range_last);
  assign cnt_ok   = (cfg.select_mode == MODE_LARGEST) || (cnt != '0);

  assign q_req.idx  = idx;
  assign q_req.cnt  = cnt;
  assign q_req.elig = in_range && cnt_ok;
  assign q_req.last = in_tlast;

  assign in_tready = q_ready;
  assign q_push    = in_tvalid && q_ready;

endmodule

// ----- design/hkts_queue.sv -----
// ----------------------------------------------------------------------------
// hkts_queue
// Small FIFO of classified bin requests between front and back.
// ----------------------------------------------------------------------------
module hkts_queue
  import hkts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  bin_req_t push_req,
  output logic     not_full,
  input  logic     pop,
  output logic     head_valid,
  output bin_req_t head_req
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  bin_req_t        mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign not_full   = (count_r != CW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_req   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

// ----- design/hkts_list.sv -----
// ----------------------------------------------------------------------------
// hkts_list
// Sorted keep list: parallel compare-and-shift insertion, one bin a cycle,
// but a final bin waits for the drain, hands it the merged list, then clears.
// ----------------------------------------------------------------------------
module hkts_list
  import hkts_pkg::*;
#(
  parameter int TOP_K = TOP_K_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          select_mode,
  input  logic                          head_valid,
  input  bin_req_t                      head_req,
  input  logic                          drain_free,
  output logic                          pop,
  output logic                          snap_load,
  output logic [IDX_W-1:0]              mrg_idx [TOP_K],
  output logic [CNT_W-1:0]              mrg_cnt [TOP_K],
  output logic [$clog2(TOP_K+1)-1:0]    mrg_fill
);

  localparam int FW = $clog2(TOP_K + 1);

  logic [IDX_W-1:0] kept_idx_r [TOP_K];
  logic [CNT_W-1:0] kept_cnt_r [TOP_K];
  logic [FW-1:0]    fill_r, fill_nxt;
  logic [TOP_K-1:0] go;

  assign pop       = head_valid && (!head_req.last || drain_free);
  assign snap_load = pop && head_req.last;

  always_comb begin
    for (int k = 0; k < TOP_K; k++) begin
      if (FW'(k) < fill_r) begin
        go[k] = (select_mode == MODE_SMALLEST) ? (head_req.cnt < kept_cnt_r[k])
                                               : (head_req.cnt > kept_cnt_r[k]);
      end else begin
        go[k] = 1'b1;
      end
    end
    for (int k = 0; k < TOP_K; k++) begin
      mrg_idx[k] = kept_idx_r[k];
      mrg_cnt[k] = kept_cnt_r[k];
      if (head_req.elig) begin
        if (k > 0 && go[(k > 0) ? k-1 : 0]) begin
          mrg_idx[k] = kept_idx_r[(k > 0) ? k-1 : 0];
          mrg_cnt[k] = kept_cnt_r[(k > 0) ? k-1 : 0];
        end else if (go[k]) begin
          mrg_idx[k] = head_req.idx;
          mrg_cnt[k] = head_req.cnt;
        end
      end
    end
    mrg_fill = fill_r;
    if (head_req.elig && fill_r != FW'(TOP_K)) begin
      mrg_fill = fill_r + 1'b1;
    end
    fill_nxt = fill_r;
    if (pop) begin
      fill_nxt = head_req.last ? '0 : mrg_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kept_idx_r <= mrg_idx;
      kept_cnt_r <= mrg_cnt;
    end
  end

endmodule

// ----- design/hkts_drain.sv -----
// ----------------------------------------------------------------------------
// hkts_drain
// Result side: holds a copy of the finished list and shifts it out by rank.
// ----------------------------------------------------------------------------
module hkts_drain
  import hkts_pkg::*;
#(
  parameter int TOP_K = TOP_K_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         snap_load,
  input  logic [IDX_W-1:0]             mrg_idx [TOP_K],
  input  logic [CNT_W-1:0]             mrg_cnt [TOP_K],
  input  logic [$clog2(TOP_K+1)-1:0]   mrg_fill,
  output logic                         drain_free,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [OUT_TDATA_W-1:0]       out_tdata,
  output logic                         out_tuser,
  output logic                         out_tlast
);

  localparam int FW = $clog2(TOP_K + 1);
  localparam int RW = (FW < RANK_W) ? RANK_W : FW;

  logic [IDX_W-1:0] snap_idx_r [TOP_K];
  logic [CNT_W-1:0] snap_cnt_r [TOP_K];
  logic [FW-1:0]    snap_fill_r;
  logic             busy_r, busy_nxt;
  logic [RW-1:0]    rank_r, rank_nxt;
  logic             take;
  logic             at_end;
  logic             ent_valid;

  assign take       = out_tvalid && out_tready;
  assign at_end     = (rank_r == RW'(TOP_K - 1));
  assign drain_free = !busy_r || (take && at_end);
  assign ent_valid  = (RW'(snap_fill_r) > rank_r);

  assign out_tvalid = busy_r;
  assign out_tlast  = at_end;
  assign out_tuser  = ent_valid;
  assign out_tdata  = {{(OUT_TDATA_W - RANK_W - IDX_W - CNT_W){1'b0}},
                       ent_valid ? snap_cnt_r[0] : {CNT_W{1'b0}},
                       ent_valid ? snap_idx_r[0] : {IDX_W{1'b0}},
                       rank_r[RANK_W-1:0]};

  always_comb begin
    busy_nxt = busy_r;
    rank_nxt = rank_r;
    if (snap_load) begin
      busy_nxt = 1'b1;
      rank_nxt = '0;
    end else if (take) begin
      rank_nxt = rank_r + 1'b1;
      if (at_end) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rank_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      rank_r <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      snap_idx_r  <= mrg_idx;
      snap_cnt_r  <= mrg_cnt;
      snap_fill_r <= mrg_fill;
    end else if (take) begin
      for (int k = 0; k < TOP_K - 1; k++) begin
        snap_idx_r[k] <= snap_idx_r[k+1];
        snap_cnt_r[k] <= snap_cnt_r[k+1];
      end
    end
  end

endmodule

// ----- design/histogram_top_k_select_core.sv -----
// ----------------------------------------------------------------------------
// histogram_top_k_select_core
// Streaming top-K selection over histogram bins (largest or smallest nonzero).
//
//   channel | dir | payload
//   in_     | in  | tdata: bin_index, bin_count; tlast: final_bin
//   out_    | out | tdata: rank, byte_value, count_value; tuser: entry_valid;
//           |     | tlast: run_end
//   cfg_    | in  | cfg_index, cfg_data
//
// One bin request per cycle through the keep list, bar the final-bin hold
// below; its compare/shift is combinational. Each run yields TOP_K results,
// one per cycle while out_tready is high, from a copy of the list, so the
// next histogram may stream in while results drain. The final bin of a run
// waits in the queue only while the previous run is still draining.
// Synchronous active-low reset empties queue, list and result stage.
// ----------------------------------------------------------------------------
module histogram_top_k_select_core
  import hkts_pkg::*;
#(
  parameter int TOP_K = TOP_K_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: [7:0] bin_index, [39:8] bin_count
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  // out_tdata: [2:0] rank, [10:3] byte_value, [42:11] count_value, zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: [0] entry_valid
  output logic                   out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int FW = $clog2(TOP_K + 1);

  cfg_t             cfg_r;
  bin_req_t         push_req;
  bin_req_t         head_req;
  logic             q_ready;
  logic             q_push;
  logic             head_valid;
  logic             pop;
  logic             snap_load;
  logic             drain_free;
  logic [IDX_W-1:0] mrg_idx [TOP_K];
  logic [CNT_W-1:0] mrg_cnt [TOP_K];
  logic [FW-1:0]    mrg_fill;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.select_mode <= MODE_LARGEST;
      cfg_r.range_first <= '0;
      cfg_r.range_last  <= RANGE_LAST_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SELECT_MODE: cfg_r.select_mode <= cfg_data[0];
        CFG_RANGE_FIRST: cfg_r.range_first <= cfg_data;
        CFG_RANGE_LAST:  cfg_r.range_last  <= cfg_data;
        default: ;
      endcase
    end
  end

  hkts_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .cfg       (cfg_r),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_req     (push_req)
  );

  hkts_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_req   (push_req),
    .not_full   (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_req   (head_req)
  );

  hkts_list #(.TOP_K(TOP_K)) u_list (
    .clk         (clk),
    .rst_n       (rst_n),
    .select_mode (cfg_r.select_mode),
    .head_valid  (head_valid),
    .head_req    (head_req),
    .drain_free  (drain_free),
    .pop         (pop),
    .snap_load   (snap_load),
    .mrg_idx     (mrg_idx),
    .mrg_cnt     (mrg_cnt),
    .mrg_fill    (mrg_fill)
  );

  hkts_drain #(.TOP_K(TOP_K)) u_drain (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_load  (snap_load),
    .mrg_idx    (mrg_idx),
    .mrg_cnt    (mrg_cnt),
    .mrg_fill   (mrg_fill),
    .drain_free (drain_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(TOP_K - 1);

  a_last_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[RANK_W-1:0] == LAST_RANK)
    else $error("run end on wrong rank");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tuser && !out_tlast |=> !(out_tvalid && out_tuser))
    else $error("valid entry after empty slot");

  a_order_largest: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser && !out_tlast &&
    cfg_r.select_mode == MODE_LARGEST
    |=> !(out_tvalid && out_tuser) ||
        out_tdata[RANK_W+IDX_W+CNT_W-1:RANK_W+IDX_W] <=
        $past(out_tdata[RANK_W+IDX_W+CNT_W-1:RANK_W+IDX_W]))
    else $error("largest-count list out of order");

  a_pop_needs_drain: assert property (@(posedge clk) disable iff (!rst_n)
    snap_load |-> drain_free && head_valid)
    else $error("list copied while drain busy");

endmodule
